/* rtl/srma_pkg.sv */
// Shared types and sizing constants for the spike-reject moving average.
// No dependencies; compile before the interfaces and modules.
package srma_pkg;

    localparam int WINDOW  = 8;
    localparam int DATA_W  = 32;
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    // Running sum: the window of samples plus one incoming sample before
    // the oldest one is removed.
    localparam int SUM_W   = DATA_W + PTR_W + 1;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [DATA_W-1:0] JUMP_LIMIT_RESET = DATA_W'(1000);

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic        [DATA_W-1:0] t_word;
    typedef logic        [PTR_W-1:0]  t_ptr;
    typedef logic        [CNT_W-1:0]  t_count;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic        [SUM_W-1:0]  t_mag;
    typedef logic signed [DIFF_W-1:0] t_diff;

    // Request to the serial divider.
    typedef struct packed {
        logic   start;
        t_mag   dividend;
        t_count divisor;
    } t_div_req;

    // Response from the serial divider.
    typedef struct packed {
        logic done;
        t_mag quotient;
    } t_div_rsp;

endpackage

/* rtl/srma_ifs.sv */
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on srma_pkg.
interface srma_sample_if;
    logic              valid;
    logic              ready;
    srma_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface srma_result_if;
    logic              valid;
    logic              ready;
    logic              accepted;
    srma_pkg::t_sample average;

    modport source (output valid, output accepted, output average, input ready);
    modport sink   (input valid, input accepted, input average, output ready);
endinterface

interface srma_cfg_if;
    logic            valid;
    logic            ready;
    srma_pkg::t_word wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

/* rtl/spike_reject_moving_average.sv */
// Top level of the spike-reject moving average filter.
// Depends on srma_pkg, the channel interfaces in srma_ifs and srma_divider.

// Each sample word is compared with the last stored sample; once the ring
// holds anything, a word whose exact absolute difference from it exceeds
// jump_limit is rejected (accepted = 0, average = 0) and nothing changes.
// Otherwise the word goes into an 8-entry ring, a running sum is updated,
// and the average is the sum divided by the fill count, truncated toward
// zero. The block takes one word at a time. A stored sample occupies
// it from accept until the serial divider, which produces one quotient
// bit per cycle, has finished; a rejected word occupies it only for the
// ring read, the registered difference and the check. The result sits
// in an output register, so a new sample word is taken while the
// previous result waits. jump_limit resets to 1000 and may be written at
// any time the block is idle; the config channel is always ready.
module spike_reject_moving_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srma_sample_if.sink i_sample,
    srma_result_if.source o_result,
    srma_cfg_if.sink    i_cfg
);
    import srma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    // Control and datapath registers.
    t_state  r_state,   n_state;
    t_word   r_limit,   n_limit;
    t_sample r_sample,  n_sample;
    t_diff   r_diff,    n_diff;
    t_ptr    r_wp,      n_wp;
    t_count  r_fill,    n_fill;
    t_sum    r_sum,     n_sum;
    logic    r_neg,     n_neg;
    logic    r_acc,     n_acc;
    t_sample r_avg,     n_avg;
    logic    r_out_valid, n_out_valid;
    logic    r_out_acc,   n_out_acc;
    t_sample r_out_avg,   n_out_avg;

    // Sample ring, one write and one registered read port.
    t_sample r_ring [WINDOW];
    t_sample r_rd_data;
    t_ptr    rd_addr;
    t_ptr    last_ptr;
    logic    ring_we;

    t_div_req div_req;
    t_div_rsp div_rsp;

    t_diff   diff_mag;
    logic    spike;
    t_mag    sum_mag;
    t_mag    quo_signed;
    logic    ring_full;

    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid    = r_out_valid;
    assign o_result.accepted = r_out_acc;
    assign o_result.average  = r_out_avg;

    assign last_ptr  = (r_wp == '0) ? PTR_W'(WINDOW - 1) : r_wp - 1'b1;
    assign ring_full = (r_fill == CNT_W'(WINDOW));

    // In idle, fetch the newest entry for the spike check; afterwards fetch
    // the slot about to be overwritten, which is the oldest once full.
    assign rd_addr = (r_state == S_IDLE) ? last_ptr : r_wp;
    assign ring_we = (r_state == S_UPDATE);

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wp] <= r_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    assign diff_mag = r_diff[DIFF_W-1] ? -r_diff : r_diff;
    assign spike    = (r_fill != '0) && (diff_mag > {1'b0, r_limit});
    assign sum_mag  = r_sum[SUM_W-1] ? t_mag'(-r_sum) : t_mag'(r_sum);
    assign quo_signed = r_neg ? -div_rsp.quotient : div_rsp.quotient;

    assign div_req.start    = (r_state == S_DIV_START);
    assign div_req.dividend = sum_mag;
    assign div_req.divisor  = r_fill;

    srma_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_sample    = r_sample;
        n_diff      = r_diff;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_avg       = r_avg;
        n_out_acc   = r_out_acc;
        n_out_avg   = r_out_avg;
        // Drop the held result once the sink takes it.
        n_out_valid = r_out_valid && !o_result.ready;

        if (i_cfg.valid) begin
            n_limit = i_cfg.wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_sample = i_sample.sample;
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                // Exact difference, one bit wider than a sample.
                n_diff  = t_diff'(r_sample) - t_diff'(r_rd_data);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (spike) begin
                    n_acc   = 1'b0;
                    n_avg   = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // Add the new sample, retire the overwritten one when full.
                n_sum = r_sum + t_sum'(r_sample)
                        - (ring_full ? t_sum'(r_rd_data) : t_sum'(0));
                n_wp  = (r_wp == PTR_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                if (!ring_full) begin
                    n_fill = r_fill + 1'b1;
                end
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                n_neg   = r_sum[SUM_W-1];
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_acc   = 1'b1;
                    n_avg   = t_sample'(quo_signed[DATA_W-1:0]);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_acc;
                    n_out_avg   = r_avg;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= JUMP_LIMIT_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_sample  <= n_sample;
        r_diff    <= n_diff;
        r_neg     <= n_neg;
        r_acc     <= n_acc;
        r_avg     <= n_avg;
        r_out_acc <= n_out_acc;
        r_out_avg <= n_out_avg;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_sum == '0))
        else $error("running sum nonzero with empty ring");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_acc) |-> (r_out_avg == '0))
        else $error("rejected result carries nonzero average");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("sample taken while previous one in flight");
`endif

endmodule

/* rtl/srma_divider.sv */
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on srma_pkg.
module srma_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srma_pkg::t_div_req i_req,
    output srma_pkg::t_div_rsp o_rsp
);
    import srma_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    t_count            r_rem;
    t_count            r_div;
    t_mag              r_quo;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_sub;

    // Shift in the next dividend bit and try a subtract.
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
